### hw/rtl/cbez_pkg.sv
// shared widths, register indexes and rounding helper for the bezier evaluator
package cbez_pkg;

  localparam int CoefW  = 27;
  localparam int ParamW = 18;
  localparam int TW     = 17;
  localparam int HW     = 30;
  localparam int PrW    = 48;
  localparam int RndW   = PrW - 16;
  localparam int SqW    = 58;
  localparam int LenW   = 59;
  localparam int SrchW  = 92;
  localparam int MagW   = 15;
  localparam int UnitW  = 16;
  localparam int NumBits = 15;
  localparam int NumRegs = 8;
  localparam int IdxW   = 3;

  localparam logic signed [ParamW-1:0] TOne = 18'sd65536;
  localparam logic signed [CoefW-1:0] PtMax = 27'sd67108863;
  localparam logic signed [CoefW-1:0] PtMin = -27'sd67108864;

  typedef logic [IdxW-1:0] reg_idx_t;
  localparam reg_idx_t REG_CUBIC_X  = 3'd0;
  localparam reg_idx_t REG_SQUARE_X = 3'd1;
  localparam reg_idx_t REG_LINEAR_X = 3'd2;
  localparam reg_idx_t REG_OFFSET_X = 3'd3;
  localparam reg_idx_t REG_CUBIC_Y  = 3'd4;
  localparam reg_idx_t REG_SQUARE_Y = 3'd5;
  localparam reg_idx_t REG_LINEAR_Y = 3'd6;
  localparam reg_idx_t REG_OFFSET_Y = 3'd7;

  typedef logic signed [CoefW-1:0] coef_t;
  typedef logic signed [HW-1:0]    hval_t;
  typedef logic signed [PrW-1:0]   prod_t;
  typedef logic signed [SrchW-1:0] srch_t;
  typedef logic signed [UnitW-1:0] unit_t;

  // floor((v + 2^15) / 2^16)
  function automatic logic signed [RndW-1:0] rnd16(input prod_t v);
    prod_t w;
    w = v + prod_t'(32768);
    return w[PrW-1:16];
  endfunction

endpackage

### hw/rtl/cubic_bezier_point_tangent_eval.sv
// cubic bezier point, unit tangent and normal evaluator, pipelined
//
// channel | ports                                   | direction
// input   | in_valid in_ready in_curve_param        | in
// result  | out_valid out_ready out_point_* out_*   | out
// config  | cfg_valid cfg_ready cfg_index cfg_data  | in
//
// one word per cycle while the result is not stalled; 23 register stages
// the unit-vector search takes one bit per stage over 15 stages
// rst_n clears valid bits and coefficients; coefficients read live
// a stalled result holds the whole pipeline, nothing is dropped
module cubic_bezier_point_tangent_eval (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [cbez_pkg::ParamW-1:0] in_curve_param,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [cbez_pkg::CoefW-1:0] out_point_x,
  output logic signed [cbez_pkg::CoefW-1:0] out_point_y,
  output logic signed [cbez_pkg::UnitW-1:0] out_tangent_x,
  output logic signed [cbez_pkg::UnitW-1:0] out_tangent_y,
  output logic signed [cbez_pkg::UnitW-1:0] out_normal_x,
  output logic signed [cbez_pkg::UnitW-1:0] out_normal_y,
  output logic                          out_degenerate,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cbez_pkg::IdxW-1:0]     cfg_index,
  input  logic signed [cbez_pkg::CoefW-1:0] cfg_data
);
  import cbez_pkg::*;

  localparam int NS = NumBits + 1;

  coef_t coef_r [NumRegs];
  logic  en;

  logic        v0_r, v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [TW-1:0] t0_r, t1_r, t2_r, t3_r, t4_r;
  prod_t m1_r [2], m3a_r [2], m2_r [2], me_r [2], m3_r [2];
  hval_t h1_r [2], e_r [2], h2_r [2], d_r [2];
  logic [SqW-1:0] sq_r [2];
  logic  dneg5_r [2];
  logic  zero5_r;
  coef_t offs5_r [2];

  logic  sv_r [NS];
  srch_t ss_r [NS][2], sp_r [NS][2], sr_r [NS][2];
  logic [LenW-1:0] sl_r [NS];
  logic [MagW-1:0] sn_r [NS][2];
  logic  sneg_r [NS][2];
  logic  sdeg_r [NS];
  coef_t spt_r [NS][2];

  srch_t ss_nxt [NS-1][2], sp_nxt [NS-1][2];
  logic [MagW-1:0] sn_nxt [NS-1][2];

  logic out_valid_r, out_deg_r;
  coef_t out_px_r, out_py_r;
  unit_t out_tx_r, out_ty_r;

  logic signed [ParamW-1:0] tcl;
  logic signed [TW:0] tsx [5];
  coef_t ca [2], cb [2], cc [2];
  logic signed [RndW-1:0] rsum [2];

  assign en = !out_valid_r || out_ready;
  assign in_ready = en;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (in_curve_param < 0) tcl = '0;
    else if (in_curve_param > TOne) tcl = TOne;
    else tcl = in_curve_param;
    tsx[0] = {1'b0, t0_r};
    tsx[1] = {1'b0, t1_r};
    tsx[2] = {1'b0, t2_r};
    tsx[3] = {1'b0, t3_r};
    tsx[4] = {1'b0, t4_r};
    ca[0] = coef_r[REG_CUBIC_X];  ca[1] = coef_r[REG_CUBIC_Y];
    cb[0] = coef_r[REG_SQUARE_X]; cb[1] = coef_r[REG_SQUARE_Y];
    cc[0] = coef_r[REG_LINEAR_X]; cc[1] = coef_r[REG_LINEAR_Y];
    for (int i = 0; i < 2; i++) begin
      rsum[i] = rnd16(m3_r[i]) + RndW'(offs5_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumRegs; i++) coef_r[i] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      coef_r[cfg_index] <= cfg_data;
    end
  end

  // front end: horner steps for point and derivative
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0; v1_r <= 1'b0; v2_r <= 1'b0;
      v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid; v1_r <= v0_r; v2_r <= v1_r;
      v3_r <= v2_r; v4_r <= v3_r; v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0_r <= tcl[TW-1:0];
      t1_r <= t0_r; t2_r <= t1_r; t3_r <= t2_r; t4_r <= t3_r;
      for (int i = 0; i < 2; i++) begin
        m1_r[i]  <= PrW'(ca[i]) * PrW'(tsx[0]);
        m3a_r[i] <= (PrW'(ca[i]) + PrW'(ca[i]) + PrW'(ca[i])) * PrW'(tsx[0]);
        h1_r[i]  <= HW'(rnd16(m1_r[i]) + RndW'(cb[i]));
        e_r[i]   <= HW'(rnd16(m3a_r[i]) + RndW'(cb[i]) + RndW'(cb[i]));
        m2_r[i]  <= PrW'(h1_r[i]) * PrW'(tsx[2]);
        me_r[i]  <= PrW'(e_r[i]) * PrW'(tsx[2]);
        h2_r[i]  <= HW'(rnd16(m2_r[i]) + RndW'(cc[i]));
        d_r[i]   <= HW'(rnd16(me_r[i]) + RndW'(cc[i]));
        m3_r[i]  <= PrW'(h2_r[i]) * PrW'(tsx[4]);
        sq_r[i]  <= SqW'(SqW'(d_r[i]) * SqW'(d_r[i]));
        dneg5_r[i] <= d_r[i] < 0;
      end
      zero5_r <= (d_r[0] == '0) && (d_r[1] == '0);
      offs5_r[0] <= coef_r[REG_OFFSET_X];
      offs5_r[1] <= coef_r[REG_OFFSET_Y];
    end
  end

  // bit search: S = (2n-1)^2 L, P = (2n-1) L, one bit per stage
  always_comb begin
    for (int j = 0; j < NS - 1; j++) begin
      srch_t cs;
      srch_t ll;
      ll = {{(SrchW-LenW){1'b0}}, sl_r[j]};
      for (int i = 0; i < 2; i++) begin
        cs = ss_r[j][i] + (sp_r[j][i] <<< (16 - j)) + (ll << (30 - 2 * j));
        if (!sn_r[j][i][MagW-1] && (cs <= sr_r[j][i])) begin
          ss_nxt[j][i] = cs;
          sp_nxt[j][i] = sp_r[j][i] + (ll << (15 - j));
          sn_nxt[j][i] = sn_r[j][i] | (MagW'(1) << (14 - j));
        end else begin
          ss_nxt[j][i] = ss_r[j][i];
          sp_nxt[j][i] = sp_r[j][i];
          sn_nxt[j][i] = sn_r[j][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NS; j++) sv_r[j] <= 1'b0;
    end else if (en) begin
      sv_r[0] <= v5_r;
      for (int j = 1; j < NS; j++) sv_r[j] <= sv_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sl_r[0]   <= LenW'(sq_r[0]) + LenW'(sq_r[1]);
      sdeg_r[0] <= zero5_r;
      for (int i = 0; i < 2; i++) begin
        sr_r[0][i]   <= {{(SrchW-SqW-30){1'b0}}, sq_r[i], 30'b0};
        ss_r[0][i]   <= {{(SrchW-LenW){1'b0}}, LenW'(sq_r[0]) + LenW'(sq_r[1])};
        sp_r[0][i]   <= -{{(SrchW-LenW){1'b0}}, LenW'(sq_r[0]) + LenW'(sq_r[1])};
        sn_r[0][i]   <= '0;
        sneg_r[0][i] <= dneg5_r[i];
        if (rsum[i] > RndW'(PtMax)) spt_r[0][i] <= PtMax;
        else if (rsum[i] < RndW'(PtMin)) spt_r[0][i] <= PtMin;
        else spt_r[0][i] <= CoefW'(rsum[i]);
      end
      for (int j = 1; j < NS; j++) begin
        sl_r[j]   <= sl_r[j-1];
        sdeg_r[j] <= sdeg_r[j-1];
        for (int i = 0; i < 2; i++) begin
          sr_r[j][i]   <= sr_r[j-1][i];
          ss_r[j][i]   <= ss_nxt[j-1][i];
          sp_r[j][i]   <= sp_nxt[j-1][i];
          sn_r[j][i]   <= sn_nxt[j-1][i];
          sneg_r[j][i] <= sneg_r[j-1][i];
          spt_r[j][i]  <= spt_r[j-1][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sv_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_px_r  <= spt_r[NS-1][0];
      out_py_r  <= spt_r[NS-1][1];
      out_deg_r <= sdeg_r[NS-1];
      if (sdeg_r[NS-1]) begin
        out_tx_r <= '0;
        out_ty_r <= '0;
      end else begin
        out_tx_r <= sneg_r[NS-1][0] ? -unit_t'(sn_r[NS-1][0]) : unit_t'(sn_r[NS-1][0]);
        out_ty_r <= sneg_r[NS-1][1] ? -unit_t'(sn_r[NS-1][1]) : unit_t'(sn_r[NS-1][1]);
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_point_x    = out_px_r;
  assign out_point_y    = out_py_r;
  assign out_tangent_x  = out_tx_r;
  assign out_tangent_y  = out_ty_r;
  assign out_normal_x   = -out_ty_r;
  assign out_normal_y   = out_tx_r;
  assign out_degenerate = out_deg_r;

endmodule

### tb/sv/cubic_bezier_point_tangent_eval_test.sv
// testbench for the cubic bezier point, tangent and normal evaluator
`timescale 1ns / 1ps

module cubic_bezier_point_tangent_eval_test;
  import cbez_pkg::*;

  typedef struct {
    logic signed [CoefW-1:0] px;
    logic signed [CoefW-1:0] py;
    logic signed [UnitW-1:0] tx;
    logic signed [UnitW-1:0] ty;
    logic signed [UnitW-1:0] nx;
    logic signed [UnitW-1:0] ny;
    logic                    degen;
  } curve_sample_t;

  class curve_scoreboard;
    longint coef[NumRegs];
    curve_sample_t pending[$];
    int errors;
    int checked;

    function longint round16(longint v);
      return (v + 64'sd32768) >>> 16;
    endfunction

    function longint horner(longint a, longint b, longint c, longint d, longint t);
      longint h;
      h = round16(a * t) + b;
      h = round16(h * t) + c;
      h = round16(h * t) + d;
      if (h > longint'(PtMax)) h = longint'(PtMax);
      if (h < longint'(PtMin)) h = longint'(PtMin);
      return h;
    endfunction

    function longint slope(longint a, longint b, longint c, longint t);
      longint e;
      e = round16(3 * a * t) + 2 * b;
      return round16(e * t) + c;
    endfunction

    function longint unit_len(longint comp, logic [127:0] len2);
      logic [127:0] lim;
      logic [127:0] k;
      longint n;
      longint cand;
      lim = 128'(comp) * 128'(comp);
      lim = lim << 30;
      n = 0;
      for (int b = 14; b >= 0; b--) begin
        cand = n | (64'sd1 << b);
        if (cand <= 16384) begin
          k = 128'(2 * cand - 1);
          if (k * k * len2 <= lim) n = cand;
        end
      end
      return n;
    endfunction

    function void note(logic signed [ParamW-1:0] param);
      curve_sample_t s;
      longint t, dx, dy, ax, ay, tx, ty;
      logic [127:0] len2;
      t = longint'(param);
      if (t < 0) t = 0;
      if (t > 65536) t = 65536;
      s.px = CoefW'(horner(coef[REG_CUBIC_X], coef[REG_SQUARE_X], coef[REG_LINEAR_X],
                           coef[REG_OFFSET_X], t));
      s.py = CoefW'(horner(coef[REG_CUBIC_Y], coef[REG_SQUARE_Y], coef[REG_LINEAR_Y],
                           coef[REG_OFFSET_Y], t));
      dx = slope(coef[REG_CUBIC_X], coef[REG_SQUARE_X], coef[REG_LINEAR_X], t);
      dy = slope(coef[REG_CUBIC_Y], coef[REG_SQUARE_Y], coef[REG_LINEAR_Y], t);
      tx = 0;
      ty = 0;
      s.degen = (dx == 0 && dy == 0);
      if (!s.degen) begin
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        len2 = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
        tx = unit_len(ax, len2);
        ty = unit_len(ay, len2);
        if (dx < 0) tx = -tx;
        if (dy < 0) ty = -ty;
      end
      s.tx = UnitW'(tx);
      s.ty = UnitW'(ty);
      s.nx = UnitW'(-ty);
      s.ny = UnitW'(tx);
      pending.insert(pending.size(), s);
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    task check(curve_sample_t got);
      curve_sample_t w;
      if (pending.size() == 0) begin
        report("unexpected word", 0, 0);
      end else begin
        w = pending.pop_front();
        checked++;
        if (got.px !== w.px) report("point_x", got.px, w.px);
        if (got.py !== w.py) report("point_y", got.py, w.py);
        if (got.tx !== w.tx) report("tangent_x", got.tx, w.tx);
        if (got.ty !== w.ty) report("tangent_y", got.ty, w.ty);
        if (got.nx !== w.nx) report("normal_x", got.nx, w.nx);
        if (got.ny !== w.ny) report("normal_y", got.ny, w.ny);
        if (got.degen !== w.degen) report("degenerate", got.degen, w.degen);
      end
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [ParamW-1:0] in_curve_param = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [CoefW-1:0] out_point_x, out_point_y;
  logic signed [UnitW-1:0] out_tangent_x, out_tangent_y, out_normal_x, out_normal_y;
  logic out_degenerate;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [IdxW-1:0] cfg_index = '0;
  logic signed [CoefW-1:0] cfg_data = '0;

  curve_scoreboard sb = new();
  int idle_max = 13;
  int out_wait = 0;
  int sent = 0;
  int degen_seen = 0;

  reg_idx_t reg_order[NumRegs] = '{REG_CUBIC_X, REG_SQUARE_X, REG_LINEAR_X, REG_OFFSET_X,
                                   REG_CUBIC_Y, REG_SQUARE_Y, REG_LINEAR_Y, REG_OFFSET_Y};

  always #2 clk = ~clk;

  cubic_bezier_point_tangent_eval u_top (.*);

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check('{out_point_x, out_point_y, out_tangent_x, out_tangent_y,
                 out_normal_x, out_normal_y, out_degenerate});
      if (out_degenerate) degen_seen++;
      out_wait = $urandom_range(idle_max, 0);
    end
    if (!rst_n) begin
      out_ready <= 0;
    end else if (out_wait > 0) begin
      out_ready <= 0;
      out_wait--;
    end else begin
      out_ready <= 1;
    end
  end

  task automatic load_coefs(longint c[NumRegs]);
    for (int i = 0; i < NumRegs; i++) begin
      cfg_valid <= 1;
      cfg_index <= reg_order[i];
      cfg_data <= CoefW'(c[i]);
      do @(posedge clk); while (!cfg_ready);
      sb.coef[reg_order[i]] = longint'(CoefW'(c[i]));
    end
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_param(logic signed [ParamW-1:0] p);
    int gap;
    gap = $urandom_range(idle_max, 0);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_curve_param <= p;
    do @(posedge clk); while (!in_ready);
    sb.note(p);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic send_directed();
    logic signed [ParamW-1:0] pts[6] = '{-18'sd131072, -18'sd1, 18'sd0, 18'sd32768,
                                         18'sd65536, 18'sd131071};
    foreach (pts[i]) send_param(pts[i]);
  endtask

  function automatic longint rand_coef(int mode);
    longint v;
    v = longint'($signed(CoefW'($urandom())));
    if (mode == 1) v = v >>> 14;
    if (mode == 2) v = v >>> 22;
    return v;
  endfunction

  initial begin
    longint c[NumRegs];
    logic signed [ParamW-1:0] p;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // all coefficients zero after reset
    send_directed();
    drain();
    foreach (c[i]) c[i] = longint'(PtMax);
    load_coefs(c);
    send_directed();
    drain();
    foreach (c[i]) c[i] = longint'(PtMin);
    load_coefs(c);
    send_directed();
    drain();
    // derivative vanishes at t = 0.5 in x, y is constant
    c = '{0, -256, 256, 0, 0, 0, 0, 1000};
    load_coefs(c);
    send_directed();
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      idle_max = (ph % 3 == 1) ? 0 : 13;
      foreach (c[i]) c[i] = rand_coef((ph + i) % 3);
      if (ph == 5) begin
        c[REG_CUBIC_Y] = 0;
        c[REG_SQUARE_Y] = 0;
        c[REG_LINEAR_Y] = 0;
      end
      load_coefs(c);
      for (int n = 0; n < 107; n++) begin
        if ($urandom_range(4, 0) == 0) p = ParamW'($urandom());
        else p = ParamW'($urandom_range(65536, 0));
        send_param(p);
      end
      drain();
    end

    $display("covered %0d parameter words over 12 coefficient sets, %0d degenerate",
             sent, degen_seen);
    $display("%0d words checked, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("Regression FAIL");
    $finish;
  end

endmodule

### files.f
hw/rtl/cbez_pkg.sv
hw/rtl/cubic_bezier_point_tangent_eval.sv
tb/sv/cubic_bezier_point_tangent_eval_test.sv
